>>> rtl/core/bfa_pkg.sv
// Shared types, constants and helpers of the best-fit block allocator.
// Used by the controller, the datapath and the top level.
// No dependencies.
`timescale 1ns / 1ps

package bfa_pkg;

    // Heap and table geometry
    localparam int MAX_BLOCKS   = 64;
    localparam int HEAP_BYTES   = 1048576;
    localparam int HEADER_BYTES = 32;
    localparam int CHUNK_BYTES  = 4096;
    localparam int MIN_BLOCK    = 32;

    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int START_W = 20;
    localparam int SIZE_W  = 21;
    localparam int TOT_W   = SIZE_W + 1;
    localparam int CMP_W   = SIZE_W + 2;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_RESIZE  = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_HEAP    = 2'd1,
        ST_TABLE   = 2'd2,
        ST_UNKNOWN = 2'd3
    } status_t;

    // One row of the block table
    typedef struct packed {
        logic                free;
        logic [SIZE_W-1:0]   bytes;
        logic [START_W-1:0]  start;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LATCH,
        CMD_SCAN_INIT,
        CMD_FIND,
        CMD_SEARCH,
        CMD_FIND_END,
        CMD_ALLOC,
        CMD_SPLIT_CHECK,
        CMD_SHIFT_INIT,
        CMD_SHIFT,
        CMD_SPLIT_W1,
        CMD_SPLIT_W0,
        CMD_RD_NEXT,
        CMD_REL_NEXT_EV,
        CMD_RD_PREV,
        CMD_REL_PREV_EV,
        CMD_REL_WRITE,
        CMD_REM_INIT_NEXT,
        CMD_REM_INIT_CUR,
        CMD_REM,
        CMD_RSZ_CHECK,
        CMD_RSZ_NEXT_EV,
        CMD_MOVE,
        CMD_DONE
    } cmd_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_FIND_INIT,
        S_FIND,
        S_FIND_END,
        S_SEARCH_INIT,
        S_SEARCH,
        S_ALLOC,
        S_SPLIT_CHECK,
        S_SHIFT_INIT,
        S_SHIFT,
        S_SPLIT_W1,
        S_SPLIT_W0,
        S_REL_NEXT_RD,
        S_REL_NEXT_EV,
        S_REL_PREV_RD,
        S_REL_PREV_EV,
        S_REL_WRITE,
        S_REM_INIT_NEXT,
        S_REM_INIT_CUR,
        S_REM,
        S_RSZ_CHECK,
        S_RSZ_NEXT_EV,
        S_MOVE,
        S_DONE
    } state_t;

    // Where a row removal returns to
    typedef enum logic [1:0] {
        RET_REL,
        RET_DONE,
        RET_SPLIT
    } ret_t;

    typedef struct packed {
        op_t  op;
        logic addr_zero;
        logic size_zero;
        logic walk_done;
        logic found;
        logic alloc_fail;
        logic split_ok;
        logic has_next;
        logic has_prev;
        logic rd_free;
        logic grow_ok;
        logic fits;
        logic out_free;
    } dp_status_t;

    // Request plus header, rounded up to 8 and to the minimum block
    function automatic logic [TOT_W-1:0] round_total(input logic [SIZE_W-1:0] size);
        logic [TOT_W-1:0] t;
        t = ({1'b0, size} + TOT_W'(HEADER_BYTES + 7)) & ~TOT_W'(7);
        if (t < TOT_W'(MIN_BLOCK))
        begin
            t = TOT_W'(MIN_BLOCK);
        end
        return t;
    endfunction

endpackage

>>> rtl/core/bfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the block table; no dependencies.
`timescale 1ns / 1ps

module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/bfa_ctrl.sv
// Sequencer of the allocator: walks each request through scan, split,
// shift, merge and result steps. Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_ctrl
    import bfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;
    logic   moving_reg, moving_next;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= RET_DONE;
            moving_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            moving_reg <= moving_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        moving_next = moving_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                moving_next = 1'b0;
                if (s_tvalid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.op)
                    OP_ALLOC:   state_next = stat.size_zero ? S_DONE : S_SEARCH_INIT;
                    OP_RELEASE: state_next = stat.addr_zero ? S_DONE : S_FIND_INIT;
                    OP_RESIZE:
                    begin
                        if (!stat.addr_zero)
                        begin
                            state_next = S_FIND_INIT;
                        end
                        else
                        begin
                            state_next = stat.size_zero ? S_DONE : S_SEARCH_INIT;
                        end
                    end
                    default:    state_next = S_DONE;
                endcase
            end
            S_FIND_INIT:   state_next = S_FIND;
            S_FIND:        state_next = stat.walk_done ? S_FIND_END : S_FIND;
            S_FIND_END:
            begin
                priority if (moving_reg)
                begin
                    state_next = S_REL_NEXT_RD;
                end
                else if (!stat.found)
                begin
                    state_next = S_DONE;
                end
                else if (stat.op == OP_RELEASE || stat.size_zero)
                begin
                    state_next = S_REL_NEXT_RD;
                end
                else
                begin
                    state_next = S_RSZ_CHECK;
                end
            end
            S_SEARCH_INIT: state_next = S_SEARCH;
            S_SEARCH:      state_next = stat.walk_done ? S_ALLOC : S_SEARCH;
            S_ALLOC:       state_next = stat.alloc_fail ? S_DONE : S_SPLIT_CHECK;
            S_SPLIT_CHECK: state_next = stat.split_ok ? S_SHIFT_INIT : S_SPLIT_W0;
            S_SHIFT_INIT:  state_next = S_SHIFT;
            S_SHIFT:       state_next = stat.walk_done ? S_SPLIT_W1 : S_SHIFT;
            S_SPLIT_W1:    state_next = S_SPLIT_W0;
            S_SPLIT_W0:    state_next = moving_reg ? S_FIND_INIT : S_DONE;
            S_REL_NEXT_RD: state_next = stat.has_next ? S_REL_NEXT_EV : S_REL_PREV_RD;
            S_REL_NEXT_EV:
            begin
                if (stat.rd_free)
                begin
                    state_next = S_REM_INIT_NEXT;
                    ret_next   = RET_REL;
                end
                else
                begin
                    state_next = S_REL_PREV_RD;
                end
            end
            S_REL_PREV_RD: state_next = stat.has_prev ? S_REL_PREV_EV : S_REL_WRITE;
            S_REL_PREV_EV:
            begin
                if (stat.rd_free)
                begin
                    state_next = S_REM_INIT_CUR;
                    ret_next   = RET_DONE;
                end
                else
                begin
                    state_next = S_REL_WRITE;
                end
            end
            S_REL_WRITE:     state_next = S_DONE;
            S_REM_INIT_NEXT: state_next = S_REM;
            S_REM_INIT_CUR:  state_next = S_REM;
            S_REM:
            begin
                if (stat.walk_done)
                begin
                    unique case (ret_reg)
                        RET_REL:   state_next = S_REL_NEXT_RD;
                        RET_SPLIT: state_next = S_SPLIT_CHECK;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_RSZ_CHECK:
            begin
                priority if (stat.fits)
                begin
                    state_next = S_SPLIT_CHECK;
                end
                else if (stat.has_next)
                begin
                    state_next = S_RSZ_NEXT_EV;
                end
                else
                begin
                    state_next = S_MOVE;
                end
            end
            S_RSZ_NEXT_EV:
            begin
                if (stat.grow_ok)
                begin
                    state_next = S_REM_INIT_NEXT;
                    ret_next   = RET_SPLIT;
                end
                else
                begin
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                moving_next = 1'b1;
                state_next  = S_SEARCH_INIT;
            end
            S_DONE:  state_next = stat.out_free ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        s_tready = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:          cmd = s_tvalid ? CMD_LATCH : CMD_NOP;
            S_FIND_INIT:     cmd = CMD_SCAN_INIT;
            S_SEARCH_INIT:   cmd = CMD_SCAN_INIT;
            S_FIND:          cmd = CMD_FIND;
            S_FIND_END:      cmd = CMD_FIND_END;
            S_SEARCH:        cmd = CMD_SEARCH;
            S_ALLOC:         cmd = CMD_ALLOC;
            S_SPLIT_CHECK:   cmd = CMD_SPLIT_CHECK;
            S_SHIFT_INIT:    cmd = CMD_SHIFT_INIT;
            S_SHIFT:         cmd = CMD_SHIFT;
            S_SPLIT_W1:      cmd = CMD_SPLIT_W1;
            S_SPLIT_W0:      cmd = CMD_SPLIT_W0;
            S_REL_NEXT_RD:   cmd = CMD_RD_NEXT;
            S_REL_NEXT_EV:   cmd = CMD_REL_NEXT_EV;
            S_REL_PREV_RD:   cmd = CMD_RD_PREV;
            S_REL_PREV_EV:   cmd = CMD_REL_PREV_EV;
            S_REL_WRITE:     cmd = CMD_REL_WRITE;
            S_REM_INIT_NEXT: cmd = CMD_REM_INIT_NEXT;
            S_REM_INIT_CUR:  cmd = CMD_REM_INIT_CUR;
            S_REM:           cmd = CMD_REM;
            S_RSZ_CHECK:     cmd = CMD_RSZ_CHECK;
            S_RSZ_NEXT_EV:   cmd = CMD_RSZ_NEXT_EV;
            S_MOVE:          cmd = CMD_MOVE;
            S_DONE:          cmd = CMD_DONE;
            default:         cmd = CMD_NOP;
        endcase
    end

endmodule

>>> rtl/core/bfa_dp.sv
// Datapath of the allocator: request registers, table RAM, scan and
// shift walkers, block arithmetic and the result register.
// Depends on bfa_pkg and bfa_ram.
`timescale 1ns / 1ps

module bfa_dp
    import bfa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output dp_status_t        stat,
    input  logic [1:0]        in_op,
    input  logic [SIZE_W-1:0] in_size,
    input  logic [SIZE_W-1:0] in_addr,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SIZE_W-1:0] out_res,
    output status_t           out_st,
    output logic [SIZE_W-1:0] out_copy
);

    // Control registers
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SIZE_W-1:0] top_reg, top_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              pv_reg, pv_next;
    logic              found_reg, found_next;
    logic              split_reg, split_next;
    logic              out_valid_reg, out_valid_next;

    // Payload registers
    op_t               op_reg, op_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SIZE_W-1:0] addr_reg, addr_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [IDX_W-1:0]  pidx_reg, pidx_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [START_W-1:0] cur_start_reg, cur_start_next;
    logic [SIZE_W-1:0] cur_bytes_reg, cur_bytes_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [SIZE_W-1:0] best_bytes_reg, best_bytes_next;
    logic [START_W-1:0] best_start_reg, best_start_next;
    logic [SIZE_W-1:0] res_reg, res_next;
    status_t           st_reg, st_next;
    logic [SIZE_W-1:0] copy_reg, copy_next;
    logic [SIZE_W-1:0] out_res_reg, out_res_next;
    status_t           out_st_reg, out_st_next;
    logic [SIZE_W-1:0] out_copy_reg, out_copy_next;

    // RAM ports
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [IDX_W-1:0]   raddr;
    entry_t             wentry;
    logic [ENTRY_W-1:0] rdata;
    entry_t             rd;

    // Derived terms
    logic               find_hit, search_q, search_exact;
    logic [TOT_W-1:0]   ext;
    logic               heap_fail, table_fail, split_ok;
    logic               walk_up, walk_down, walk_done;
    logic [SIZE_W-1:0]  grow_sum, old_payload;
    logic               grow_ok, fits, has_next, out_free;

    bfa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wentry),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd = entry_t'(rdata);

    // Block arithmetic
    assign find_hit     = !rd.free &&
                          (({1'b0, rd.start} + SIZE_W'(HEADER_BYTES)) == addr_reg);
    assign search_q     = rd.free && ({1'b0, rd.bytes} >= total_reg) &&
                          (!found_reg || (rd.bytes < best_bytes_reg));
    assign search_exact = search_q && ({1'b0, rd.bytes} == total_reg);
    assign ext          = (total_reg < TOT_W'(CHUNK_BYTES)) ? TOT_W'(CHUNK_BYTES) : total_reg;
    assign heap_fail    = ({2'b00, top_reg} + {1'b0, ext}) > CMP_W'(HEAP_BYTES);
    assign table_fail   = cnt_reg >= CNT_W'(MAX_BLOCKS);
    assign split_ok     = !table_fail &&
                          ({2'b00, cur_bytes_reg} >=
                           ({1'b0, total_reg} + CMP_W'(HEADER_BYTES + MIN_BLOCK)));
    assign grow_sum     = cur_bytes_reg + rd.bytes;
    assign grow_ok      = rd.free && ({1'b0, grow_sum} >= total_reg);
    assign fits         = total_reg <= {1'b0, cur_bytes_reg};
    assign old_payload  = (cur_bytes_reg > SIZE_W'(HEADER_BYTES)) ?
                          (cur_bytes_reg - SIZE_W'(HEADER_BYTES)) : '0;
    assign has_next     = ({1'b0, i_reg} + CNT_W'(1)) < cnt_reg;
    assign out_free     = !out_valid_reg || out_ready;

    // Walker bounds: upward to the row count, downward to the working row
    assign walk_up   = k_reg < cnt_reg;
    assign walk_down = k_reg > {1'b0, i_reg};

    always_comb
    begin
        unique case (cmd)
            CMD_FIND:   walk_done = (!pv_reg && !walk_up) || (pv_reg && find_hit);
            CMD_SEARCH: walk_done = (!pv_reg && !walk_up) || (pv_reg && search_exact);
            CMD_SHIFT:  walk_done = !pv_reg && !walk_down;
            CMD_REM:    walk_done = !pv_reg && !walk_up;
            default:    walk_done = 1'b0;
        endcase
    end

    // Status to the controller
    always_comb
    begin
        stat.op         = op_reg;
        stat.addr_zero  = (addr_reg == '0);
        stat.size_zero  = (size_reg == '0);
        stat.walk_done  = walk_done;
        stat.found      = found_reg;
        stat.alloc_fail = !found_reg && (heap_fail || table_fail);
        stat.split_ok   = split_ok;
        stat.has_next   = has_next;
        stat.has_prev   = (i_reg != '0);
        stat.rd_free    = rd.free;
        stat.grow_ok    = grow_ok;
        stat.fits       = fits;
        stat.out_free   = out_free;
    end

    // Command execution
    always_comb
    begin
        cnt_next        = cnt_reg;
        top_next        = top_reg;
        k_next          = k_reg;
        pv_next         = pv_reg;
        found_next      = found_reg;
        split_next      = split_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        op_next         = op_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        total_next      = total_reg;
        pidx_next       = pidx_reg;
        i_next          = i_reg;
        cur_start_next  = cur_start_reg;
        cur_bytes_next  = cur_bytes_reg;
        best_idx_next   = best_idx_reg;
        best_bytes_next = best_bytes_reg;
        best_start_next = best_start_reg;
        res_next        = res_reg;
        st_next         = st_reg;
        copy_next       = copy_reg;
        out_res_next    = out_res_reg;
        out_st_next     = out_st_reg;
        out_copy_next   = out_copy_reg;
        we              = 1'b0;
        waddr           = i_reg;
        wentry          = rd;
        raddr           = k_reg[IDX_W-1:0];

        unique case (cmd)
            CMD_LATCH:
            begin
                op_next    = op_t'(in_op);
                size_next  = in_size;
                addr_next  = in_addr;
                total_next = round_total(in_size);
                res_next   = '0;
                st_next    = ST_OK;
                copy_next  = '0;
            end
            CMD_SCAN_INIT:
            begin
                k_next     = '0;
                pv_next    = 1'b0;
                found_next = 1'b0;
            end
            CMD_FIND, CMD_SEARCH:
            begin
                // one row issued and one evaluated per cycle
                pv_next = walk_up;
                if (walk_up)
                begin
                    k_next    = k_reg + CNT_W'(1);
                    pidx_next = k_reg[IDX_W-1:0];
                end
                if (pv_reg && cmd == CMD_FIND && find_hit)
                begin
                    found_next     = 1'b1;
                    i_next         = pidx_reg;
                    cur_start_next = rd.start;
                    cur_bytes_next = rd.bytes;
                end
                if (pv_reg && cmd == CMD_SEARCH && search_q)
                begin
                    found_next      = 1'b1;
                    best_idx_next   = pidx_reg;
                    best_bytes_next = rd.bytes;
                    best_start_next = rd.start;
                end
            end
            CMD_FIND_END:
            begin
                if (!found_reg)
                begin
                    st_next = ST_UNKNOWN;
                end
            end
            CMD_ALLOC:
            begin
                priority if (found_reg)
                begin
                    i_next         = best_idx_reg;
                    cur_start_next = best_start_reg;
                    cur_bytes_next = best_bytes_reg;
                    res_next       = {1'b0, best_start_reg} + SIZE_W'(HEADER_BYTES);
                end
                else if (heap_fail || table_fail)
                begin
                    st_next   = heap_fail ? ST_HEAP : ST_TABLE;
                    res_next  = '0;
                    copy_next = '0;
                end
                else
                begin
                    // append a new row at the heap top
                    i_next         = cnt_reg[IDX_W-1:0];
                    cur_start_next = top_reg[START_W-1:0];
                    cur_bytes_next = ext[SIZE_W-1:0];
                    cnt_next       = cnt_reg + CNT_W'(1);
                    top_next       = top_reg + ext[SIZE_W-1:0];
                    res_next       = top_reg + SIZE_W'(HEADER_BYTES);
                end
            end
            CMD_SPLIT_CHECK:
            begin
                split_next = split_ok;
            end
            CMD_SHIFT_INIT:
            begin
                k_next  = cnt_reg - CNT_W'(1);
                pv_next = 1'b0;
            end
            CMD_SHIFT:
            begin
                // move rows above the working row up by one
                pv_next = walk_down;
                if (walk_down)
                begin
                    k_next    = k_reg - CNT_W'(1);
                    pidx_next = k_reg[IDX_W-1:0];
                end
                we     = pv_reg;
                waddr  = pidx_reg + IDX_W'(1);
                wentry = rd;
            end
            CMD_SPLIT_W1:
            begin
                we           = 1'b1;
                waddr        = i_reg + IDX_W'(1);
                wentry.free  = 1'b1;
                wentry.bytes = cur_bytes_reg - total_reg[SIZE_W-1:0];
                wentry.start = cur_start_reg + total_reg[START_W-1:0];
                cnt_next     = cnt_reg + CNT_W'(1);
            end
            CMD_SPLIT_W0:
            begin
                we           = 1'b1;
                waddr        = i_reg;
                wentry.free  = 1'b0;
                wentry.bytes = split_reg ? total_reg[SIZE_W-1:0] : cur_bytes_reg;
                wentry.start = cur_start_reg;
            end
            CMD_RD_NEXT:
            begin
                raddr = i_reg + IDX_W'(1);
            end
            CMD_REL_NEXT_EV:
            begin
                if (rd.free)
                begin
                    cur_bytes_next = grow_sum;
                end
            end
            CMD_RD_PREV:
            begin
                raddr = i_reg - IDX_W'(1);
            end
            CMD_REL_PREV_EV:
            begin
                // merge into a free predecessor
                we           = rd.free;
                waddr        = i_reg - IDX_W'(1);
                wentry.free  = 1'b1;
                wentry.bytes = grow_sum;
                wentry.start = rd.start;
            end
            CMD_REL_WRITE:
            begin
                we           = 1'b1;
                waddr        = i_reg;
                wentry.free  = 1'b1;
                wentry.bytes = cur_bytes_reg;
                wentry.start = cur_start_reg;
            end
            CMD_REM_INIT_NEXT:
            begin
                k_next  = {1'b0, i_reg} + CNT_W'(2);
                pv_next = 1'b0;
            end
            CMD_REM_INIT_CUR:
            begin
                k_next  = {1'b0, i_reg} + CNT_W'(1);
                pv_next = 1'b0;
            end
            CMD_REM:
            begin
                // move rows down by one over the removed row
                pv_next = walk_up;
                if (walk_up)
                begin
                    k_next    = k_reg + CNT_W'(1);
                    pidx_next = k_reg[IDX_W-1:0];
                end
                we     = pv_reg;
                waddr  = pidx_reg - IDX_W'(1);
                wentry = rd;
                if (walk_done)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            CMD_RSZ_CHECK:
            begin
                raddr = i_reg + IDX_W'(1);
                if (fits)
                begin
                    res_next = addr_reg;
                end
            end
            CMD_RSZ_NEXT_EV:
            begin
                if (grow_ok)
                begin
                    cur_bytes_next = grow_sum;
                    res_next       = addr_reg;
                end
            end
            CMD_MOVE:
            begin
                copy_next = (old_payload < size_reg) ? old_payload : size_reg;
            end
            CMD_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    out_st_next    = st_reg;
                    out_copy_next  = copy_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            top_reg       <= '0;
            k_reg         <= '0;
            pv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            split_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            top_reg       <= top_next;
            k_reg         <= k_next;
            pv_reg        <= pv_next;
            found_reg     <= found_next;
            split_reg     <= split_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        total_reg      <= total_next;
        pidx_reg       <= pidx_next;
        i_reg          <= i_next;
        cur_start_reg  <= cur_start_next;
        cur_bytes_reg  <= cur_bytes_next;
        best_idx_reg   <= best_idx_next;
        best_bytes_reg <= best_bytes_next;
        best_start_reg <= best_start_next;
        res_reg        <= res_next;
        st_reg         <= st_next;
        copy_reg       <= copy_next;
        out_res_reg    <= out_res_next;
        out_st_reg     <= out_st_next;
        out_copy_reg   <= out_copy_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_st    = out_st_reg;
    assign out_copy  = out_copy_reg;

endmodule

>>> rtl/core/best_fit_block_allocator.sv
// Best-fit heap allocator with split and coalesce, one request at a time.
// The block table (64 rows of start, size and free mark) lives in a
// single-port-read RAM, so every walk over it reads the rows one at a
// time. A split adds the shift of the rows above the working row. A
// release walks the table once more for each neighbor that it merges
// with. A moving resize looks up, allocates, looks up again and
// releases. The next request is taken while the previous result still
// waits in the output register.
// Depends on bfa_pkg, bfa_ctrl and bfa_dp.
`timescale 1ns / 1ps

module best_fit_block_allocator
    import bfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // request_size[20:0], address[41:21], zero pad
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // result_address[20:0], status[22:21],
                                   // copy_length[43:23], zero pad
);

    cmd_t              cmd;
    dp_status_t        stat;
    logic [SIZE_W-1:0] out_res;
    status_t           out_st;
    logic [SIZE_W-1:0] out_copy;

    bfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bfa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_op     (s_tuser),
        .in_size   (s_tdata[20:0]),
        .in_addr   (s_tdata[41:21]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res),
        .out_st    (out_st),
        .out_copy  (out_copy)
    );

    // Result packing
    assign m_tdata = {4'b0000, out_copy, out_st, out_res};

endmodule

>>> verif/tb.sv
// Self-checking testbench for best_fit_block_allocator.
// It holds its own model of the block table, drives requests with random gaps
// and back-pressure, and checks every result. Depends on bfa_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
    import bfa_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT  = 1500000;

    typedef logic [23:0] wide_t;

    typedef struct {
        logic [20:0] grant;
        status_t     st;
        logic [20:0] copy;
    } answer_t;

    typedef struct {
        op_t         op;
        logic [20:0] size;
        logic [20:0] addr;
        bit          fixed;
        logic [20:0] grant;
        status_t     st;
        logic [20:0] copy;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    best_fit_block_allocator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Model of the block table
    wide_t   row_start [MAX_BLOCKS];
    wide_t   row_bytes [MAX_BLOCKS];
    bit      row_free  [MAX_BLOCKS];
    int      row_count;
    wide_t   heap_end;

    answer_t pending_answers [$];
    int      mismatches;
    int      sent_items;
    int      cycles;

    function automatic wide_t total_bytes(wide_t size);
        wide_t t;
        t = (size + wide_t'(HEADER_BYTES + 7)) & ~wide_t'(7);
        if (t < wide_t'(MIN_BLOCK))
        begin
            t = wide_t'(MIN_BLOCK);
        end
        return t;
    endfunction

    function automatic void drop_row(int pos);
        for (int k = pos; k + 1 < row_count; k++)
        begin
            row_start[k] = row_start[k+1];
            row_bytes[k] = row_bytes[k+1];
            row_free[k]  = row_free[k+1];
        end
        row_count--;
    endfunction

    function automatic void split_row(int i, wide_t total);
        if (row_count >= MAX_BLOCKS ||
            row_bytes[i] < total + wide_t'(HEADER_BYTES + MIN_BLOCK))
        begin
            return;
        end
        for (int k = row_count; k > i + 1; k--)
        begin
            row_start[k] = row_start[k-1];
            row_bytes[k] = row_bytes[k-1];
            row_free[k]  = row_free[k-1];
        end
        row_start[i+1] = row_start[i] + total;
        row_bytes[i+1] = row_bytes[i] - total;
        row_free[i+1]  = 1'b1;
        row_bytes[i]   = total;
        row_count++;
    endfunction

    function automatic int row_of_payload(wide_t addr);
        for (int i = 0; i < row_count; i++)
        begin
            if (!row_free[i] && row_start[i] + wide_t'(HEADER_BYTES) == addr)
            begin
                return i;
            end
        end
        return row_count;
    endfunction

    // Free a row, absorb free followers, then merge into a free predecessor
    function automatic void free_row(int i);
        row_free[i] = 1'b1;
        while (i + 1 < row_count && row_free[i+1])
        begin
            row_bytes[i] += row_bytes[i+1];
            drop_row(i + 1);
        end
        if (i > 0 && row_free[i-1])
        begin
            row_bytes[i-1] += row_bytes[i];
            drop_row(i);
        end
    endfunction

    function automatic status_t grab(wide_t size, output wide_t paddr);
        wide_t total;
        wide_t best_bytes;
        wide_t ext;
        int    best;
        bit    found;
        paddr = '0;
        best_bytes = '0;
        best = 0;
        found = 0;
        if (size == 0)
        begin
            return ST_OK;
        end
        total = total_bytes(size);
        for (int i = 0; i < row_count; i++)
        begin
            if (row_free[i] && row_bytes[i] >= total && (!found || row_bytes[i] < best_bytes))
            begin
                found = 1;
                best = i;
                best_bytes = row_bytes[i];
                if (best_bytes == total)
                begin
                    break;
                end
            end
        end
        if (!found)
        begin
            ext = (total < wide_t'(CHUNK_BYTES)) ? wide_t'(CHUNK_BYTES) : total;
            if (heap_end + ext > wide_t'(HEAP_BYTES))
            begin
                return ST_HEAP;
            end
            if (row_count >= MAX_BLOCKS)
            begin
                return ST_TABLE;
            end
            best = row_count;
            row_start[best] = heap_end;
            row_bytes[best] = ext;
            row_count++;
            heap_end += ext;
        end
        row_free[best] = 1'b0;
        split_row(best, total);
        paddr = row_start[best] + wide_t'(HEADER_BYTES);
        return ST_OK;
    endfunction

    // Expected answer for one request; updates the table model
    function automatic answer_t serve(logic [1:0] op, wide_t size, wide_t addr);
        answer_t a;
        wide_t   total;
        wide_t   old_payload;
        wide_t   paddr;
        int      i;
        a.grant = '0;
        a.st = ST_OK;
        a.copy = '0;
        paddr = '0;
        if (op == OP_ALLOC || (op == OP_RESIZE && addr == 0))
        begin
            a.st = grab(size, paddr);
            a.grant = paddr[20:0];
        end
        else if (op == OP_RELEASE && addr != 0)
        begin
            i = row_of_payload(addr);
            if (i >= row_count)
                a.st = ST_UNKNOWN;
            else
                free_row(i);
        end
        else if (op == OP_RESIZE)
        begin
            i = row_of_payload(addr);
            total = total_bytes(size);
            if (i >= row_count)
            begin
                a.st = ST_UNKNOWN;
            end
            else if (size == 0)
            begin
                free_row(i);
            end
            else if (total <= row_bytes[i])
            begin
                split_row(i, total);
                a.grant = addr[20:0];
            end
            else if (i + 1 < row_count && row_free[i+1] && row_bytes[i] + row_bytes[i+1] >= total)
            begin
                row_bytes[i] += row_bytes[i+1];
                drop_row(i + 1);
                split_row(i, total);
                a.grant = addr[20:0];
            end
            else
            begin
                old_payload = (row_bytes[i] > wide_t'(HEADER_BYTES)) ?
                              row_bytes[i] - wide_t'(HEADER_BYTES) : '0;
                a.st = grab(size, paddr);
                if (a.st == ST_OK)
                begin
                    a.grant = paddr[20:0];
                    a.copy = (old_payload < size) ? old_payload[20:0] : size[20:0];
                    free_row(row_of_payload(addr));
                end
            end
        end
        return a;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(4, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [20:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        if (r < 70)
            return 21'($urandom_range(512, 1));
        if (r < 90)
            return 21'($urandom_range(8192, 513));
        if (r < 97)
            return 21'($urandom_range(200000, 8193));
        return 21'($urandom_range(21'h1FFFFF));
    endfunction

    function automatic logic [20:0] pick_live();
        int live [$];
        for (int i = 0; i < row_count; i++)
        begin
            if (!row_free[i])
                live.push_back(int'(row_start[i]) + HEADER_BYTES);
        end
        if (live.size() == 0)
            return '0;
        return 21'(live[$urandom_range(live.size() - 1)]);
    endfunction

    // Offer one request and wait for it to be taken
    task automatic send(row_t r);
        int      g;
        answer_t a;
        g = pick_gap();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {6'b0, r.addr, r.size};
        do
            @(posedge clk);
        while (!s_tready);
        a = serve(r.op, wide_t'(r.size), wide_t'(r.addr));
        if (r.fixed)
        begin
            a.grant = r.grant;
            a.st = r.st;
            a.copy = r.copy;
        end
        pending_answers.push_back(a);
        sent_items++;
        @(negedge clk);
    endtask

    // Clock and cycle limit
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        answer_t a;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h", m_tdata);
            end
            else
            begin
                a = pending_answers.pop_front();
                if (m_tdata[20:0] !== a.grant || m_tdata[22:21] !== a.st
                    || m_tdata[43:23] !== a.copy)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected addr %0d st %0d copy %0d, got %0d %0d %0d",
                                 a.grant, a.st, a.copy, m_tdata[20:0], m_tdata[22:21],
                                 m_tdata[43:23]);
                end
            end
        end
    end

    // Receiver: random back-pressure plus one long hold-off
    initial
    begin
        int  g;
        bit  held;
        held = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            g = pick_gap();
            if (!held && sent_items >= 150)
            begin
                held = 1;
                g = 600;
            end
            if (g > 0)
            begin
                m_tready <= 1'b0;
                repeat (g) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(negedge clk);
        end
    end

    // Stimulus
    initial
    begin
        row_t plan [$];
        row_t r;
        int   p;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        mismatches = 0;
        sent_items = 0;
        cycles = 0;
        row_count = 0;
        heap_end = '0;
        for (int i = 0; i < MAX_BLOCKS; i++)
            row_free[i] = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed requests; fixed rows carry their answer
        plan = '{
            '{OP_ALLOC,   21'd0,       21'd0,       1, 21'd0,  ST_OK,      21'd0},
            '{OP_RELEASE, 21'd0,       21'd0,       1, 21'd0,  ST_OK,      21'd0},
            '{OP_RELEASE, 21'd0,       21'd1000,    1, 21'd0,  ST_UNKNOWN, 21'd0},
            '{OP_RESIZE,  21'd40,      21'd0,       1, 21'd32, ST_OK,      21'd0},
            '{OP_ALLOC,   21'd1,       21'd0,       0, 21'd0,  ST_OK,      21'd0},
            '{OP_ALLOC,   21'd4064,    21'd0,       0, 21'd0,  ST_OK,      21'd0},
            '{OP_ALLOC,   21'd1048576, 21'd0,       1, 21'd0,  ST_HEAP,    21'd0},
            '{OP_ALLOC,   21'h1FFFFF,  21'd0,       1, 21'd0,  ST_HEAP,    21'd0},
            '{OP_NONE,    21'h1FFFFF,  21'h1FFFFF,  1, 21'd0,  ST_OK,      21'd0},
            '{OP_RESIZE,  21'd8,       21'd32,      0, 21'd0,  ST_OK,      21'd0},
            '{OP_RESIZE,  21'd100,     21'd32,      0, 21'd0,  ST_OK,      21'd0},
            '{OP_RELEASE, 21'd0,       21'd104,     0, 21'd0,  ST_OK,      21'd0},
            '{OP_RELEASE, 21'd0,       21'd104,     1, 21'd0,  ST_UNKNOWN, 21'd0},
            '{OP_RELEASE, 21'd0,       21'd33,      1, 21'd0,  ST_UNKNOWN, 21'd0},
            '{OP_RELEASE, 21'd0,       21'h1FFFFF,  1, 21'd0,  ST_UNKNOWN, 21'd0},
            '{OP_RESIZE,  21'd0,       21'd4128,    0, 21'd0,  ST_OK,      21'd0},
            '{OP_RESIZE,  21'd5000,    21'd9999,    1, 21'd0,  ST_UNKNOWN, 21'd0},
            '{OP_ALLOC,   21'd2000,    21'd0,       0, 21'd0,  ST_OK,      21'd0},
            '{OP_ALLOC,   21'd200,     21'd0,       0, 21'd0,  ST_OK,      21'd0},
            '{OP_RESIZE,  21'd3000,    21'd0,       0, 21'd0,  ST_OK,      21'd0},
            '{OP_ALLOC,   21'd600000,  21'd0,       0, 21'd0,  ST_OK,      21'd0}
        };
        foreach (plan[i])
            send(plan[i]);

        // Random mix, mostly well-formed on live blocks
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 300)
            begin
                s_tvalid <= 1'b0;
                while (pending_answers.size() != 0)
                    @(negedge clk);
                @(negedge clk);
            end
            r = '{OP_ALLOC, 21'd0, 21'd0, 0, 21'd0, ST_OK, 21'd0};
            p = $urandom_range(99);
            r.size = pick_size();
            if (p < 42)
            begin
                r.op = OP_ALLOC;
                r.addr = 21'($urandom_range(21'h1FFFFF));
            end
            else if (p < 68)
            begin
                r.op = OP_RELEASE;
                r.addr = pick_live();
            end
            else if (p < 88)
            begin
                r.op = OP_RESIZE;
                r.addr = pick_live();
            end
            else if (p < 96)
            begin
                r.op = ($urandom_range(1) != 0) ? OP_RELEASE : OP_RESIZE;
                r.addr = 21'($urandom_range(21'h1FFFFF));
            end
            else
            begin
                r.op = OP_NONE;
                r.size = 21'($urandom_range(21'h1FFFFF));
                r.addr = 21'($urandom_range(21'h1FFFFF));
            end
            send(r);
        end
        s_tvalid <= 1'b0;

        // Drain, then a quiet tail
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/bfa_pkg.sv
rtl/core/bfa_ram.sv
rtl/core/bfa_ctrl.sv
rtl/core/bfa_dp.sv
rtl/core/best_fit_block_allocator.sv
verif/tb.sv
